### design/cma_pkg.sv
// Shared types and constants for the centered moving average block.
package cma_pkg;

    localparam int INDEX_BITS = 32;
    localparam int CFG_BITS   = 7;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

endpackage

### design/cma_if.sv
// Valid/ready channel interfaces for the sample input and the average output.
interface cma_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first_of_series;
    logic                          last_of_series;

    modport source (output valid, output sample, output first_of_series,
                    output last_of_series, input ready);
    modport sink   (input valid, input sample, input first_of_series,
                    input last_of_series, output ready);
endinterface

interface cma_out_if #(
    parameter int SAMPLE_BITS = 24
);
    import cma_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic [INDEX_BITS-1:0]         center_index;

    modport source (output valid, output average, output center_index, input ready);
    modport sink   (input valid, input average, input center_index, output ready);
endinterface

### design/cma_div.sv
// Restoring serial divider: one quotient bit per cycle, unsigned operands.
module cma_div #(
    parameter int DIVIDEND_BITS = 31,
    parameter int DIVISOR_BITS  = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_BITS-1:0] i_dividend,
    input  logic [DIVISOR_BITS-1:0]  i_divisor,
    output logic                     o_busy,
    output logic [DIVIDEND_BITS-1:0] o_quotient
);
    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [DIVISOR_BITS-1:0]  r_dvs;
    logic [CNT_BITS-1:0]      r_cnt;
    logic                     r_busy;

    logic [DIVISOR_BITS:0]    trial;
    logic                     fits;
    logic [DIVISOR_BITS:0]    diff;

    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_BITS-1]};
        fits  = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(DIVIDEND_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_BITS-2:0], fits};
            r_rem <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

### design/centered_moving_average.sv
// Centered moving average filter: top level with sequencer, sample ring and running sum.
//
// Each accepted word carries one signed fixed-point sample. The block keeps the most recent
// samples in a ring memory and a running sum of the newest window samples; once a full window
// has arrived in the current series, every new sample yields one average word, the sum divided
// by the window and truncated toward zero, tagged with the series position of the window's
// center sample. The window register takes a requested length; an even value is raised by one
// and the result is limited to the largest odd value below MAX_WINDOW. Writing the window also
// starts a new series. A sample marked first of series clears the history before it is taken,
// and a sample marked last of series clears it after its own step. The input is taken one word
// at a time: a word that gives no result passes through the read and update states, and one
// that does also starts the serial divider, which produces one quotient bit per cycle, waits
// for it and emits the average once the output register is free. A finished average waits in
// an output register, so the next word is taken while it is still pending downstream.
module centered_moving_average #(
    parameter int MAX_WINDOW  = 128,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cma_pkg::CFG_BITS-1:0] i_cfg_wdata,
    cma_in_if.sink                       i_in,
    cma_out_if.source                    o_out
);
    import cma_pkg::*;

    localparam int PTR_BITS  = $clog2(MAX_WINDOW);
    localparam int WIN_BITS  = PTR_BITS;
    localparam int FILL_BITS = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + WIN_BITS;
    localparam int CAP       = ((MAX_WINDOW - 1) % 2 == 1) ? MAX_WINDOW - 1 : MAX_WINDOW - 2;

    // Turns a requested length into the odd window actually used.
    function automatic logic [WIN_BITS-1:0] eff_window(input logic [CFG_BITS-1:0] req);
        logic [CFG_BITS-1:0] odd;
        odd = req | CFG_BITS'(1);
        if (32'(odd) > CAP) begin
            return WIN_BITS'(CAP);
        end
        return WIN_BITS'(odd);
    endfunction

    t_state r_state, n_state;

    logic [WIN_BITS-1:0]          r_win;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                         r_last;
    logic signed [SUM_BITS-1:0]   r_sum;
    logic [FILL_BITS-1:0]         r_fill;
    logic [INDEX_BITS-1:0]        r_idx;
    logic [PTR_BITS-1:0]          r_wp;
    logic signed [SAMPLE_BITS-1:0] r_rd;
    logic                         r_neg;

    logic                         r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_avg;
    logic [INDEX_BITS-1:0]        r_center;

    // Sample ring; an entry read out is only used after being written in the current series.
    logic [SAMPLE_BITS-1:0]       r_hist [MAX_WINDOW];

    logic                         in_acc;
    logic                         div_start;
    logic                         div_busy;
    logic [SUM_BITS-1:0]          quotient;
    logic [SUM_BITS-1:0]          sum_mag;
    logic [PTR_BITS:0]            old_diff;
    logic [PTR_BITS-1:0]          old_addr;
    logic [FILL_BITS-1:0]         fill_inc;
    logic                         full_before;
    logic                         full_after;
    logic                         out_free;
    logic [SUM_BITS-1:0]          avg_full;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Address of the sample that leaves the window: write pointer minus window, modulo ring size.
    always_comb begin
        old_diff = {1'b0, r_wp} - {1'b0, r_win};
        if (old_diff[PTR_BITS]) begin
            old_addr = PTR_BITS'(old_diff + (PTR_BITS + 1)'(MAX_WINDOW));
        end else begin
            old_addr = old_diff[PTR_BITS-1:0];
        end
    end

    always_comb begin
        fill_inc    = (r_fill == FILL_BITS'(MAX_WINDOW)) ? r_fill : r_fill + 1'b1;
        full_before = r_fill >= FILL_BITS'(r_win);
        full_after  = fill_inc >= FILL_BITS'(r_win);
        sum_mag     = r_sum[SUM_BITS-1] ? SUM_BITS'(-r_sum) : SUM_BITS'(r_sum);
        avg_full    = r_neg ? -quotient : quotient;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ:      n_state = S_UPDATE;
            S_UPDATE:    n_state = full_after ? S_DIV_START : S_IDLE;
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (!div_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // State-decoded outputs.
    always_comb begin
        i_in.ready = 1'b0;
        div_start  = 1'b0;
        case (r_state)
            S_IDLE:      i_in.ready = 1'b1;
            S_DIV_START: div_start  = 1'b1;
            default: begin
                i_in.ready = 1'b0;
                div_start  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window register, running sum, fill count, series position and write pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= eff_window(WINDOW_RESET);
            r_sum  <= '0;
            r_fill <= '0;
            r_idx  <= '0;
            r_wp   <= '0;
        end else if (i_cfg_we) begin
            r_win  <= eff_window(i_cfg_wdata);
            r_sum  <= '0;
            r_fill <= '0;
            r_idx  <= '0;
            r_wp   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.first_of_series) begin
                        r_sum  <= '0;
                        r_fill <= '0;
                        r_idx  <= '0;
                        r_wp   <= '0;
                    end
                end
                S_READ: begin
                    r_sum <= r_sum + SUM_BITS'(r_sample);
                end
                S_UPDATE: begin
                    if (!full_after && r_last) begin
                        // No result for this word and the series ends here.
                        r_sum  <= '0;
                        r_fill <= '0;
                        r_idx  <= '0;
                        r_wp   <= '0;
                    end else begin
                        if (full_before) begin
                            r_sum <= r_sum - SUM_BITS'(r_rd);
                        end
                        r_fill <= fill_inc;
                        r_wp   <= (r_wp == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
                        if (!full_after) begin
                            // No result for this word: finish the step here.
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_last) begin
                            r_sum  <= '0;
                            r_fill <= '0;
                            r_idx  <= '0;
                            r_wp   <= '0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload captured at acceptance and sign of the dividend.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_in.sample;
            r_last   <= i_in.last_of_series;
        end
        if (r_state == S_DIV_START) begin
            r_neg <= r_sum[SUM_BITS-1];
        end
    end

    // Ring memory: the new sample is written while the leaving sample is read.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_hist[r_wp] <= r_sample;
            r_rd         <= r_hist[old_addr];
        end
    end

    cma_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (WIN_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_mag),
        .i_divisor  (r_win),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // Output register; the center lies half a window behind the newest sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_avg    <= avg_full[SAMPLE_BITS-1:0];
            r_center <= r_idx - INDEX_BITS'(r_win >> 1);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.average      = r_avg;
    assign o_out.center_index = r_center;
endmodule

### tb/sv/centered_moving_average_tb.sv
// Testbench for the centered moving average filter: stimulus, prediction and checking.
`timescale 1ns / 1ps

module centered_moving_average_tb;

    import cma_pkg::*;

    localparam int MAX_WINDOW   = 128;
    localparam int SAMPLE_BITS  = 24;
    localparam int CLK_HALF     = 2;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 900;
    // A word that gives no average can keep the block busy after the last average has
    // left, so configuration waits SETTLE_CYCLES more once the queue is empty.
    localparam int SETTLE_CYCLES = 40;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] average;
        logic [INDEX_BITS-1:0]         center_index;
    } t_avg_word;

    // The checker keeps its own copy of the sample ring, the running sum and the series
    // counters, works out the average that each accepted sample word should give, and
    // compares every average word leaving the block against the oldest one still pending.
    class moving_average_checker;
        logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
        longint                        window_sum;
        int                            held;
        int                            head;
        logic [INDEX_BITS-1:0]         next_pos;
        logic [CFG_BITS-1:0]           window_reg;
        t_avg_word                     pending_averages [$];
        int                            failures;
        int                            checked;

        function new();
            window_reg = WINDOW_RESET;
            failures   = 0;
            checked    = 0;
            restart_series();
        endfunction

        function void restart_series();
            window_sum = 0;
            held       = 0;
            head       = 0;
            next_pos   = '0;
        endfunction

        function void set_window(logic [CFG_BITS-1:0] req);
            window_reg = req;
            restart_series();
        endfunction

        // Requested length made odd and clipped to the largest odd value the ring holds.
        function int odd_window();
            int w;
            int cap;
            w   = int'(window_reg) | 1;
            cap = MAX_WINDOW - 1;
            if (cap % 2 == 0) begin
                cap = cap - 1;
            end
            if (w > cap) begin
                w = cap;
            end
            return w;
        endfunction

        function void take_sample(logic signed [SAMPLE_BITS-1:0] smp, bit first, bit last);
            int        w;
            int        half;
            t_avg_word word;
            longint    quot;
            if (first) begin
                restart_series();
            end
            w    = odd_window();
            half = (w - 1) / 2;
            if (held >= w) begin
                window_sum -= longint'(ring[(head + MAX_WINDOW - w) % MAX_WINDOW]);
            end
            window_sum += longint'(smp);
            ring[head] = smp;
            head       = (head + 1) % MAX_WINDOW;
            if (held < MAX_WINDOW) begin
                held++;
            end
            if (held >= w) begin
                // Signed division of a longint truncates toward zero, as the block must.
                quot              = window_sum / longint'(w);
                word.average      = quot[SAMPLE_BITS-1:0];
                word.center_index = next_pos - INDEX_BITS'(half);
                pending_averages.push_back(word);
            end
            next_pos = next_pos + 1;
            if (last) begin
                restart_series();
            end
        endfunction

        function void check_average(logic signed [SAMPLE_BITS-1:0] avg,
                                    logic [INDEX_BITS-1:0] center);
            t_avg_word want;
            checked++;
            if (pending_averages.size() == 0) begin
                $display("%0t: average word with none pending: average %0d center %0d",
                         $time, avg, center);
                failures++;
                return;
            end
            want = pending_averages.pop_front();
            if (avg !== want.average) begin
                $display("%0t: average mismatch: expected %0d, actual %0d",
                         $time, want.average, avg);
                failures++;
            end
            if (center !== want.center_index) begin
                $display("%0t: center index mismatch: expected %0d, actual %0d",
                         $time, want.center_index, center);
                failures++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_BITS-1:0] i_cfg_wdata;

    cma_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    cma_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

    centered_moving_average #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    moving_average_checker board = new();

    int cycles       = 0;
    int words_sent   = 0;
    int burst_left   = 1;
    int window_count = 0;

    always begin
        #CLK_HALF i_clk = ~i_clk;
    end

    // The run is cut off at a generous limit in case the block stops moving words.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d averages pending",
                     cycles, board.pending_averages.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver switches at random between behaviors: always ready, a coin toss per
    // cycle, rare stalls, or long stretches of stall.
    int stall_style = 0;
    int style_left  = 0;
    int stall_left  = 0;

    always @(negedge i_clk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(50, 300);
        end else begin
            style_left--;
        end
        case (stall_style)
            0: begin
                out_ch.ready <= 1'b1;
            end
            1: begin
                out_ch.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                out_ch.ready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end else begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(5, 30);
                    end
                    out_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    // Every average word accepted at a rising edge goes to the checker.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.check_average(out_ch.average, out_ch.center_index);
        end
    end

    // Drops valid at the next falling edge and keeps it low until the task returns; the
    // payload carries junk meanwhile, which the block must ignore.
    task automatic idle_input(int n);
        @(negedge i_clk);
        in_ch.valid           <= 1'b0;
        in_ch.sample          <= SAMPLE_BITS'($urandom());
        in_ch.first_of_series <= 1'($urandom_range(0, 1));
        in_ch.last_of_series  <= 1'($urandom_range(0, 1));
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Offers one sample word and waits for its handshake; the sender works in bursts
    // with random gaps between them, and some bursts run straight into the next.
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp, bit first, bit last);
        @(negedge i_clk);
        in_ch.valid           <= 1'b1;
        in_ch.sample          <= smp;
        in_ch.first_of_series <= first;
        in_ch.last_of_series  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        board.take_sample(smp, first, last);
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                idle_input($urandom_range(1, 12));
            end
        end
    endtask

    // The window is written only with the block idle: valid low, no average pending,
    // and SETTLE_CYCLES more for a word that gives no average to finish.
    task automatic write_window(logic [CFG_BITS-1:0] req);
        idle_input(1);
        while (board.pending_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= req;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= CFG_BITS'($urandom());
        board.set_window(req);
        window_count++;
    endtask

    // Extremes, small values near zero and full-range values.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_BITS'($signed($urandom_range(0, 20)) - 10);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // One window setting, then series of random length: most are well formed with the
    // first and last marks in place; some lose a mark or get a stray one in the middle.
    task automatic run_phase(logic [CFG_BITS-1:0] req, int n_words);
        int w_eff;
        int left;
        int len;
        int broken_at;
        bit first;
        bit last;
        write_window(req);
        w_eff = board.odd_window();
        left  = n_words;
        while (left > 0) begin
            if (w_eff < 20) begin
                len = $urandom_range(1, 3 * w_eff + 6);
            end else begin
                len = $urandom_range(w_eff, 2 * w_eff + 10);
            end
            if (len > left) begin
                len = left;
            end
            broken_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : -1;
            for (int i = 0; i < len; i++) begin
                first = (i == 0) && ($urandom_range(0, 9) != 0);
                last  = (i == len - 1) && ($urandom_range(0, 6) != 0);
                if (i == broken_at) begin
                    first = 1'($urandom_range(0, 1));
                    last  = 1'($urandom_range(0, 1));
                end
                send_sample(pick_sample(), first, last);
                left--;
            end
        end
    endtask

    initial begin
        int                  random_words;
        int                  w_eff;
        int                  phase_words;
        logic [CFG_BITS-1:0] req;

        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        in_ch.valid           = 1'b0;
        in_ch.sample          = '0;
        in_ch.first_of_series = 1'b0;
        in_ch.last_of_series  = 1'b0;
        out_ch.ready          = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of three: full-scale sums both ways, truncation of negative sums
        // toward zero, a new series opened mid-stream, and both marks on one word.
        send_sample(SAMPLE_MAX, 1'b1, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(24'sd7, 1'b1, 1'b0);
        send_sample(-24'sd2, 1'b0, 1'b0);
        send_sample(-24'sd4, 1'b0, 1'b0);
        send_sample(-24'sd1, 1'b0, 1'b1);
        send_sample(24'sd5, 1'b1, 1'b1);
        send_sample(-24'sd1, 1'b0, 1'b0);
        send_sample(24'sd0, 1'b0, 1'b0);
        send_sample(-24'sd1, 1'b0, 1'b1);

        // A zero window acts as a window of one: each word is its own average, and a
        // word carrying both marks still gives its average.
        write_window('0);
        send_sample(SAMPLE_MAX, 1'b1, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(-24'sd1, 1'b0, 1'b0);
        send_sample(24'sd0, 1'b0, 1'b1);
        send_sample(24'sd123, 1'b1, 1'b1);

        // An even window is raised to the next odd one; the write itself opens a series.
        write_window(CFG_BITS'(2));
        send_sample(24'sd3, 1'b0, 1'b0);
        send_sample(-24'sd9, 1'b0, 1'b0);
        send_sample(24'sd4, 1'b0, 1'b0);
        send_sample(-24'sd9, 1'b0, 1'b0);

        // Random part: the largest windows first, then mostly short ones.
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            case (window_count)
                2: req = CFG_BITS'(127);
                3: req = CFG_BITS'(126);
                4: req = '0;
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        req = CFG_BITS'($urandom_range(0, 127));
                    end else begin
                        req = CFG_BITS'($urandom_range(0, 12));
                    end
                end
            endcase
            w_eff = (int'(req) | 1) > MAX_WINDOW - 1 ? MAX_WINDOW - 1 : (int'(req) | 1);
            if (w_eff < 20) begin
                phase_words = $urandom_range(50, 90);
            end else begin
                phase_words = 2 * w_eff + $urandom_range(10, 40);
            end
            // The last phase is cut short so the run stays near its word budget.
            if (phase_words > RANDOM_WORDS - random_words) begin
                phase_words = RANDOM_WORDS - random_words;
            end
            run_phase(req, phase_words);
            random_words = words_sent - 23;
        end

        idle_input(1);
        while (board.pending_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.pending_averages.size() != 0) begin
            $display("%0t: %0d averages never arrived", $time, board.pending_averages.size());
            board.failures++;
        end

        $display("Sent %0d sample words over %0d window settings; checked %0d averages.",
                 words_sent, window_count, board.checked);
        $display("Mismatches and stray words: %0d, in %0d cycles.", board.failures, cycles);
        if (board.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
